// ===== hdl/vlff_pkg.sv =====
// Package for the voxel light flood fill block.
// Holds the sequencer state type and fixed constants; no dependencies.
`default_nettype none
package vlff_pkg;

   localparam logic [7:0] AIR_TYPE = 8'd0;
   localparam logic [3:0] FLOOD_MARGIN = 4'd2;
   localparam logic [3:0] SUN_RESET = 4'd15;
   localparam logic OP_READ = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,     // clear the stores after reset
      ST_IDLE,
      ST_SCAN_RD,   // issue read of a column cell
      ST_SCAN_WR,   // write light, push to queue
      ST_POP,       // issue read of queue head
      ST_POP_WAIT,  // queue data back, read its light
      ST_NB_RD,     // issue read of one neighbour
      ST_NB_WR,     // check neighbour and maybe light it
      ST_RESULT_RD, // read addressed cell
      ST_RESULT     // present result
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/voxel_light_flood_fill.sv =====
// Top level of the voxel light flood fill block.
// Uses vlff_pkg; holds the type, light and queue memories and the sequencer.
//
// Usage: raise start with req_operation, req_x_coord/y/z and req_new_type
// while busy is low; the item is taken at that edge and busy rises. A read
// passes ST_RESULT_RD, which registers the cell, and ST_RESULT, which shows
// it on rsp_* for one cycle, marked by rsp_strobe, then can take the next item.
// A write stores the type and relights the grid: one column pass over every
// cell, with a read state and a write state per cell, then the breadth-first
// flood: ST_POP and ST_POP_WAIT per dequeued cell, then ST_NB_RD for each of
// its six neighbours and ST_NB_WR for each in-grid one. Out-of-grid items go
// straight to ST_RESULT, answer status 1 and change nothing.
// csr_wr_en/csr_wr_data set the sun level; write it only while idle.
// Reset: synchronous, active high. After reset a clearing pass sets every cell
// to air with light 0; busy stays high meanwhile.
// The receiver cannot stall; each result is shown exactly once.
`default_nettype none
module voxel_light_flood_fill
   import vlff_pkg::*;
#(
   parameter int SIDE = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [5:0]  req_x_coord,
   input  wire logic [5:0]  req_y_coord,
   input  wire logic [5:0]  req_z_coord,
   input  wire logic [7:0]  req_new_type,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_cell_type,
   output logic [3:0]       rsp_cell_light,
   output logic             rsp_status
);

   localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int AW = 3 * CW;
   localparam int CELLS = SIDE * SIDE * SIDE;
   localparam int DEPTH = 1 << AW;
   localparam int QW = AW + 1;
   localparam logic [CW-1:0] TOP = CW'(SIDE - 1);

   // type and light stores addressed by packed {x, y, z}; the queue holds such addresses
   logic [7:0]    type_mem [DEPTH];
   logic [3:0]    light_mem [DEPTH];
   logic [AW-1:0] queue_mem [DEPTH];

   state_type state_ff, state_in;
   logic [3:0]    sun_ff;
   logic [CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;     // scan / current cell
   logic [CW-1:0] rx_ff, ry_ff, rz_ff;                    // requested cell
   logic [AW-1:0] clr_ff;
   logic          sky_ff, sky_in;                          // still above ground
   logic [AW-1:0] head_ff, head_in;
   logic [QW-1:0] count_ff, count_in;
   logic [3:0]    level_ff;
   logic [2:0]    dir_ff, dir_in;
   logic [AW-1:0] nb_ff;
   logic          nb_ok;
   logic [AW-1:0] nb_addr;
   logic [7:0]    type_q;
   logic [3:0]    light_q;
   logic [AW-1:0] queue_q;
   logic          out_status_ff;
   logic          req_ok;

   function automatic logic [AW-1:0] cell_of(logic [CW-1:0] x, logic [CW-1:0] y,
                                               logic [CW-1:0] z);
      cell_of = {x, y, z};
   endfunction

   function automatic logic coord_ok(logic [5:0] c);
      coord_ok = (c[5] == 1'b0) && ({1'b0, c[4:0]} < 6'(SIDE));
   endfunction

   assign req_ok = coord_ok(req_x_coord) && coord_ok(req_y_coord) && coord_ok(req_z_coord);

   // neighbour of the current cell for direction dir_ff
   always_comb begin
      logic [CW-1:0] nx, ny, nz;
      nx = x_ff; ny = y_ff; nz = z_ff;
      nb_ok = 1'b1;
      case (dir_ff)
         3'd0: begin nb_ok = (x_ff != '0);  nx = x_ff - 1'b1; end
         3'd1: begin nb_ok = (x_ff != TOP); nx = x_ff + 1'b1; end
         3'd2: begin nb_ok = (z_ff != '0);  nz = z_ff - 1'b1; end
         3'd3: begin nb_ok = (z_ff != TOP); nz = z_ff + 1'b1; end
         3'd4: begin nb_ok = (y_ff != '0);  ny = y_ff - 1'b1; end
         default: begin nb_ok = (y_ff != TOP); ny = y_ff + 1'b1; end
      endcase
      nb_addr = cell_of(nx, ny, nz);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               if (!req_ok) state_in = ST_RESULT;
               else if (req_operation == OP_WRITE) state_in = ST_SCAN_RD;
               else state_in = ST_RESULT_RD;
            end
         end
         ST_SCAN_RD:   state_in = ST_SCAN_WR;
         ST_SCAN_WR: begin
            if (y_ff == '0 && z_ff == TOP && x_ff == TOP) state_in = ST_POP;
            else state_in = ST_SCAN_RD;
         end
         ST_POP:       state_in = (count_ff == '0) ? ST_RESULT_RD : ST_POP_WAIT;
         ST_POP_WAIT:  state_in = ST_NB_RD;
         ST_NB_RD:     state_in = nb_ok ? ST_NB_WR : ((dir_ff == 3'd5) ? ST_POP : ST_NB_RD);
         ST_NB_WR:     state_in = (dir_ff == 3'd5) ? ST_POP : ST_NB_RD;
         ST_RESULT_RD: state_in = ST_RESULT;
         ST_RESULT:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      sky_in = sky_ff; head_in = head_ff; count_in = count_ff; dir_in = dir_ff;
      unique case (state_ff)
         ST_IDLE: begin
            x_in = '0; z_in = '0; y_in = TOP; sky_in = 1'b1;
            head_in = '0; count_in = '0;
         end
         ST_SCAN_WR: begin
            if (sky_ff && type_q == AIR_TYPE) count_in = count_ff + 1'b1;
            else sky_in = 1'b0;
            if (y_ff == '0) begin
               y_in = TOP; sky_in = 1'b1;
               if (z_ff == TOP) begin z_in = '0; x_in = x_ff + 1'b1; end
               else z_in = z_ff + 1'b1;
            end else y_in = y_ff - 1'b1;
         end
         ST_POP: begin
            head_in = head_ff + 1'b1;
            if (count_ff != '0) count_in = count_ff - 1'b1;
         end
         ST_POP_WAIT: begin
            x_in = queue_q[3*CW-1:2*CW]; y_in = queue_q[2*CW-1:CW];
            z_in = queue_q[CW-1:0]; dir_in = '0;
         end
         ST_NB_RD: if (!nb_ok) dir_in = dir_ff + 1'b1;
         ST_NB_WR: begin
            if (type_q == AIR_TYPE && ({1'b0, light_q} + {1'b0, FLOOD_MARGIN}) <= {1'b0, level_ff})
               count_in = count_ff + 1'b1;
            dir_in = dir_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // memories: one access each per cycle
   always_ff @(posedge clock) begin
      logic [AW-1:0] tail;
      tail = head_ff + count_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            type_mem[clr_ff] <= AIR_TYPE;
            light_mem[clr_ff] <= 4'd0;
         end
         ST_IDLE: if (start && req_ok && req_operation == OP_WRITE)
            type_mem[cell_of(req_x_coord[CW-1:0], req_y_coord[CW-1:0], req_z_coord[CW-1:0])]
               <= req_new_type;
         ST_SCAN_RD: type_q <= type_mem[cell_of(x_ff, y_ff, z_ff)];
         ST_SCAN_WR: begin
            if (sky_ff && type_q == AIR_TYPE) begin
               light_mem[cell_of(x_ff, y_ff, z_ff)] <= sun_ff;
               queue_mem[tail] <= cell_of(x_ff, y_ff, z_ff);
            end else light_mem[cell_of(x_ff, y_ff, z_ff)] <= 4'd0;
         end
         ST_POP: queue_q <= queue_mem[head_ff];
         ST_POP_WAIT: light_q <= light_mem[queue_q];
         ST_NB_RD: if (nb_ok) begin
            type_q <= type_mem[nb_addr];
            light_q <= light_mem[nb_addr];
            nb_ff <= nb_addr;
         end
         ST_NB_WR: if (type_q == AIR_TYPE &&
                       ({1'b0, light_q} + {1'b0, FLOOD_MARGIN}) <= {1'b0, level_ff}) begin
            light_mem[nb_ff] <= level_ff - 1'b1;
            queue_mem[tail] <= nb_ff;
         end
         ST_RESULT_RD: begin
            type_q <= type_mem[cell_of(rx_ff, ry_ff, rz_ff)];
            light_q <= light_mem[cell_of(rx_ff, ry_ff, rz_ff)];
         end
         default: ;
      endcase
      if (state_ff == ST_NB_RD && dir_ff == 3'd0) level_ff <= light_q;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         sun_ff <= SUN_RESET;
         head_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_wr_en) sun_ff <= csr_wr_data;
         head_ff <= head_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      sky_ff <= sky_in; dir_ff <= dir_in;
      if (state_ff == ST_IDLE && start) begin
         rx_ff <= req_x_coord[CW-1:0];
         ry_ff <= req_y_coord[CW-1:0];
         rz_ff <= req_z_coord[CW-1:0];
         out_status_ff <= !req_ok;
      end
   end

   // outputs
   always_comb begin
      busy = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_RESULT);
      rsp_status = out_status_ff;
      rsp_cell_type = out_status_ff ? AIR_TYPE : type_q;
      rsp_cell_light = out_status_ff ? 4'd0 : light_q;
   end

   // queue never holds more than the grid
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QW'(CELLS)) else $error("queue overflow");
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double result");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");

endmodule
`default_nettype wire
